### rtl/pfcs_pkg.sv
package pfcs_pkg;

    localparam logic [7:0] CRC_POLY  = 8'h31;
    localparam logic [7:0] CRC_INIT  = 8'hFF;
    localparam logic [3:0] LAST_STARTUP = 4'd8;
    localparam logic [3:0] LAST_MEAS    = 4'd2;
    localparam logic [3:0] IDX_IDLE     = 4'd15;
    localparam logic [4:0] CRC_STEPS    = 5'd8;
    localparam logic [4:0] DIV_STEPS    = 5'd19;
    localparam logic [4:0] PRESS_MUL    = 5'd10;
    localparam logic [15:0] PRESS_MAX   = 16'h7FFF;
    localparam logic [15:0] PRESS_MIN   = 16'h8000;

    localparam logic KIND_STARTUP = 1'b0;
    localparam logic KIND_MEAS    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CRC  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    function automatic logic [7:0] crc_step(input logic [7:0] v);
        logic [7:0] r;
        r = {v[6:0], 1'b0};
        if (v[7]) begin
            r = r ^ CRC_POLY;
        end
        return r;
    endfunction

endpackage

### rtl/pfcs_in_if.sv
interface pfcs_in_if;
    logic       valid;
    logic       ready;
    logic       first;
    logic       cmd;
    logic [7:0] rx_byte;
    logic       bus_ok;

    modport source (output valid, output first, output cmd, output rx_byte, output bus_ok,
                    input ready);
    modport sink   (input valid, input first, input cmd, input rx_byte, input bus_ok,
                    output ready);
endinterface

### rtl/pfcs_out_if.sv
interface pfcs_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic               present;
    logic               reading_ok;
    logic signed [15:0] pressure;
    logic        [15:0] scale_out;

    modport source (output valid, output kind, output present, output reading_ok,
                    output pressure, output scale_out, input ready);
    modport sink   (input valid, input kind, input present, input reading_ok,
                    input pressure, input scale_out, output ready);
endinterface

### rtl/pressure_frame_crc_scaler_unit.sv
// Checks sensor response bytes against CRC-8 (poly 0x31, init 0xFF) and scales
// measurements. A startup frame (9 bytes) latches its third word as the scale
// factor when all CRCs match and the bus reports success; a measurement frame
// (3 bytes) yields pressure = signed raw * 10 / scale, truncated toward zero and
// saturated to 16 bits, or 0 with reading_ok clear. One transaction comes out
// per completed frame. A data byte is accepted and then stepped through the
// bit-serial CRC unit; a CRC byte is checked as it is accepted. The CRC byte that
// ends a good measurement frame first runs the one-bit-per-cycle restoring
// divider; every frame end then loads the output register, and the load waits
// while the previous result is still held. The input is ready only while the
// sequencer idles; the output register lets a new byte enter while a result
// waits.
module pressure_frame_crc_scaler_unit
    import pfcs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    pfcs_in_if.sink       i_in,
    pfcs_out_if.source    o_out
);

    t_state       r_state, n_state;
    logic [4:0]   r_cnt, n_cnt;
    logic [3:0]   r_byte_index, n_byte_index;
    logic         r_frame_mode, n_frame_mode;
    logic [7:0]   r_crc, n_crc;
    logic         r_words_good, n_words_good;
    logic [15:0]  r_word_hold, n_word_hold;
    logic [15:0]  r_scale, n_scale;
    logic         r_present, n_present;
    logic         r_o_valid, n_o_valid;

    logic [16:0]  r_rem, n_rem;
    logic [18:0]  r_dq, n_dq;
    logic         r_neg, n_neg;
    logic         r_res_kind, n_res_kind;
    logic         r_res_ok, n_res_ok;
    logic [15:0]  r_res_press, n_res_press;

    logic         r_o_kind, n_o_kind;
    logic         r_o_present, n_o_present;
    logic         r_o_ok, n_o_ok;
    logic [15:0]  r_o_press, n_o_press;
    logic [15:0]  r_o_scale, n_o_scale;

    logic         accept;
    logic [3:0]   eff_idx;
    logic         eff_mode;
    logic         eff_wg;
    logic [3:0]   last_idx;
    logic         match;
    logic         wg_new;
    logic signed [19:0] prod;
    logic [19:0]  prod_mag;
    logic [16:0]  rem_sh;
    logic [16:0]  rem_sub;
    logic [18:0]  dq_next;
    logic [16:0]  rem_next;
    logic [18:0]  quot;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    assign eff_idx  = i_in.first ? 4'd0 : r_byte_index;
    assign eff_mode = i_in.first ? i_in.cmd : r_frame_mode;
    assign eff_wg   = i_in.first ? 1'b1 : r_words_good;
    assign last_idx = eff_mode ? LAST_MEAS : LAST_STARTUP;
    assign match    = (r_crc == i_in.rx_byte);
    assign wg_new   = eff_wg && match;

    assign prod     = 20'(signed'(r_word_hold)) * signed'({15'd0, PRESS_MUL});
    assign prod_mag = prod[19] ? (20'd0 - 20'(prod)) : 20'(prod);

    assign rem_sh   = {r_rem[15:0], r_dq[18]};
    assign rem_sub  = rem_sh - {1'b0, r_scale};
    assign rem_next = rem_sub[16] ? rem_sh : rem_sub;
    assign dq_next  = {r_dq[17:0], ~rem_sub[16]};
    assign quot     = dq_next;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_byte_index = r_byte_index;
        n_frame_mode = r_frame_mode;
        n_crc        = r_crc;
        n_words_good = r_words_good;
        n_word_hold  = r_word_hold;
        n_scale      = r_scale;
        n_present    = r_present;
        n_rem        = r_rem;
        n_dq         = r_dq;
        n_neg        = r_neg;
        n_res_kind   = r_res_kind;
        n_res_ok     = r_res_ok;
        n_res_press  = r_res_press;
        n_o_valid    = r_o_valid && !o_out.ready;
        n_o_kind     = r_o_kind;
        n_o_present  = r_o_present;
        n_o_ok       = r_o_ok;
        n_o_press    = r_o_press;
        n_o_scale    = r_o_scale;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_frame_mode = eff_mode;
                    n_words_good = eff_wg;
                    n_byte_index = eff_idx;
                    if (i_in.first && !i_in.cmd) begin
                        n_present = 1'b0;
                    end
                    if (eff_idx <= last_idx) begin
                        case (eff_idx) inside
                            4'd0, 4'd3, 4'd6: begin
                                n_crc        = CRC_INIT ^ i_in.rx_byte;
                                n_word_hold  = {i_in.rx_byte, 8'h00};
                                n_byte_index = eff_idx + 4'd1;
                                n_cnt        = 5'd0;
                                n_state      = ST_CRC;
                            end
                            4'd1, 4'd4, 4'd7: begin
                                n_crc        = r_crc ^ i_in.rx_byte;
                                n_word_hold  = {r_word_hold[15:8], i_in.rx_byte};
                                n_byte_index = eff_idx + 4'd1;
                                n_cnt        = 5'd0;
                                n_state      = ST_CRC;
                            end
                            default: begin
                                n_words_good = wg_new;
                                n_crc        = CRC_INIT;
                                if (eff_idx != last_idx) begin
                                    n_byte_index = eff_idx + 4'd1;
                                end else begin
                                    n_byte_index = IDX_IDLE;
                                    n_res_ok     = 1'b0;
                                    n_res_press  = 16'd0;
                                    if (eff_mode == KIND_STARTUP) begin
                                        n_res_kind = KIND_STARTUP;
                                        if (wg_new && i_in.bus_ok) begin
                                            n_scale   = r_word_hold;
                                            n_present = 1'b1;
                                        end else begin
                                            n_present = 1'b0;
                                        end
                                        n_state = ST_EMIT;
                                    end else begin
                                        n_res_kind = KIND_MEAS;
                                        if (match && r_present && (r_scale != 16'd0)) begin
                                            n_res_ok = 1'b1;
                                            n_neg    = prod[19];
                                            n_dq     = prod_mag[18:0];
                                            n_rem    = 17'd0;
                                            n_cnt    = 5'd0;
                                            n_state  = ST_DIV;
                                        end else begin
                                            n_state = ST_EMIT;
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            ST_CRC: begin
                n_crc = crc_step(r_crc);
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == CRC_STEPS - 5'd1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                n_rem = rem_next;
                n_dq  = dq_next;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == DIV_STEPS - 5'd1) begin
                    if (!r_neg) begin
                        n_res_press = (quot > 19'(PRESS_MAX)) ? PRESS_MAX : quot[15:0];
                    end else begin
                        n_res_press = (quot > 19'(PRESS_MIN)) ? PRESS_MIN
                                                              : (16'd0 - quot[15:0]);
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid   = 1'b1;
                    n_o_kind    = r_res_kind;
                    n_o_present = r_present;
                    n_o_ok      = r_res_ok;
                    n_o_press   = r_res_press;
                    n_o_scale   = r_scale;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= 5'd0;
            r_byte_index <= 4'd0;
            r_frame_mode <= 1'b0;
            r_crc        <= CRC_INIT;
            r_words_good <= 1'b1;
            r_word_hold  <= 16'd0;
            r_scale      <= 16'd0;
            r_present    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_byte_index <= n_byte_index;
            r_frame_mode <= n_frame_mode;
            r_crc        <= n_crc;
            r_words_good <= n_words_good;
            r_word_hold  <= n_word_hold;
            r_scale      <= n_scale;
            r_present    <= n_present;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_dq        <= n_dq;
        r_neg       <= n_neg;
        r_res_kind  <= n_res_kind;
        r_res_ok    <= n_res_ok;
        r_res_press <= n_res_press;
        r_o_kind    <= n_o_kind;
        r_o_present <= n_o_present;
        r_o_ok      <= n_o_ok;
        r_o_press   <= n_o_press;
        r_o_scale   <= n_o_scale;
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.kind       = r_o_kind;
    assign o_out.present    = r_o_present;
    assign o_out.reading_ok = r_o_ok;
    assign o_out.pressure   = signed'(r_o_press);
    assign o_out.scale_out  = r_o_scale;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pfcs_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int LONG_HOLD    = 700;
    localparam int FLOOD_ITEMS  = 90;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic               kind;
        logic               present;
        logic               reading_ok;
        logic signed [15:0] pressure;
        logic        [15:0] scale_out;
    } t_frame_result;

    class frame_result_book;
        logic [3:0]      idx;
        logic            mode;
        logic [7:0]      crc;
        logic            all_good;
        logic [15:0]     word;
        logic [15:0]     scale;
        logic            present;
        t_frame_result   pending_results[$];
        int              fail_count;

        function new();
            idx        = 4'd0;
            mode       = KIND_STARTUP;
            crc        = CRC_INIT;
            all_good   = 1'b1;
            word       = 16'h0000;
            scale      = 16'h0000;
            present    = 1'b0;
            fail_count = 0;
        endfunction

        static function logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] b);
            logic [7:0] v;
            v = acc ^ b;
            for (int k = 0; k < 8; k++) begin
                v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
            end
            return v;
        endfunction

        static function logic [7:0] word_crc(logic [15:0] w);
            return crc8_next(crc8_next(CRC_INIT, w[15:8]), w[7:0]);
        endfunction

        task report(string line);
            $display("%s", line);
            fail_count++;
        endtask

        function int pending();
            return pending_results.size();
        endfunction

        function void take_byte(logic f, logic c, logic [7:0] b, logic ok);
            logic [3:0]    last;
            logic          hit;
            int            raw_s;
            int            div;
            int            q;
            t_frame_result r;
            hit = 1'b0;
            if (f) begin
                idx      = 4'd0;
                mode     = c;
                crc      = CRC_INIT;
                all_good = 1'b1;
                if (c == KIND_STARTUP) present = 1'b0;
            end
            last = (mode == KIND_MEAS) ? LAST_MEAS : LAST_STARTUP;
            if (idx > last) return;
            case (idx % 3)
                0: begin
                    crc  = crc8_next(CRC_INIT, b);
                    word = {b, 8'h00};
                end
                1: begin
                    crc       = crc8_next(crc, b);
                    word[7:0] = b;
                end
                default: begin
                    hit = (crc == b);
                    if (!hit) all_good = 1'b0;
                    crc = CRC_INIT;
                end
            endcase
            if (idx != last) begin
                idx = idx + 4'd1;
                return;
            end
            idx = IDX_IDLE;
            r   = '0;
            if (mode == KIND_STARTUP) begin
                if (all_good && ok) begin
                    scale   = word;
                    present = 1'b1;
                end else begin
                    present = 1'b0;
                end
                r.kind = KIND_STARTUP;
            end else begin
                r.kind       = KIND_MEAS;
                r.reading_ok = hit && present && (scale != 16'h0000);
                if (r.reading_ok) begin
                    raw_s = $signed(word);
                    div   = scale;
                    q     = (raw_s * 10) / div;
                    if (q > 32767)  q = 32767;
                    if (q < -32768) q = -32768;
                    r.pressure = q[15:0];
                end
            end
            r.present   = present;
            r.scale_out = scale;
            pending_results.push_back(r);
        endfunction

        task check_result(t_frame_result got);
            t_frame_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result kind=%0d pressure=%0d",
                                 got.kind, got.pressure));
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.present !== want.present)
                report($sformatf("present %0d, want %0d", got.present, want.present));
            if (got.reading_ok !== want.reading_ok)
                report($sformatf("reading_ok %0d, want %0d", got.reading_ok,
                                 want.reading_ok));
            if (got.pressure !== want.pressure)
                report($sformatf("pressure %0d, want %0d", got.pressure, want.pressure));
            if (got.scale_out !== want.scale_out)
                report($sformatf("scale_out %0d, want %0d", got.scale_out,
                                 want.scale_out));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    pfcs_in_if  in_if();
    pfcs_out_if out_if();

    pressure_frame_crc_scaler_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    frame_result_book book;
    int               cycle_count;
    int               sent_bytes;
    int               stray_bytes;
    int               got_results;
    bit               offering;
    bit               flood_on;
    bit               held;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_byte(input logic f, input logic c, input logic [7:0] b,
                             input logic ok);
        int gap;
        gap = (flood_on || ((sent_bytes / 120) % 5 == 4)) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            if (offering) in_if.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.first   <= f;
        in_if.cmd     <= c;
        in_if.rx_byte <= b;
        in_if.bus_ok  <= ok;
        offering = 1'b1;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        book.take_byte(f, c, b, ok);
        sent_bytes++;
    endtask

    task automatic send_word(input logic f, input logic c, input logic [15:0] w,
                             input bit good_crc, input logic last_ok);
        logic [7:0] k;
        k = frame_result_book::word_crc(w);
        if (!good_crc) k = k ^ 8'($urandom_range(1, 255));
        send_byte(f, c, w[15:8], 1'($urandom));
        send_byte(1'b0, 1'($urandom), w[7:0], 1'($urandom));
        send_byte(1'b0, 1'($urandom), k, last_ok);
    endtask

    task automatic send_startup(input logic f, input logic [15:0] scale,
                                input bit good_crc, input logic ok);
        int bad_word;
        bad_word = good_crc ? 3 : $urandom_range(0, 2);
        send_word(f, KIND_STARTUP, 16'($urandom), bad_word != 0, 1'($urandom));
        send_word(1'b0, KIND_STARTUP, 16'($urandom), bad_word != 1, 1'($urandom));
        send_word(1'b0, KIND_STARTUP, scale, bad_word != 2, ok);
    endtask

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'(2 + $urandom_range(0, 1));
            3:       return 16'd10;
            4, 5:    return 16'($urandom_range(1, 100));
            6:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int pick;
        int n;
        logic c;
        book        = new();
        cycle_count = 0;
        sent_bytes  = 0;
        stray_bytes = 0;
        offering    = 1'b0;
        flood_on    = 1'b0;
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.first   <= 1'b0;
        in_if.cmd     <= 1'b0;
        in_if.rx_byte <= 8'h00;
        in_if.bus_ok  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // startup taken from index 0 without a first marker, then saturating reads
        send_startup(1'b0, 16'h0001, 1'b1, 1'b1);
        send_word(1'b1, KIND_MEAS, 16'h7FFF, 1'b1, 1'b1);
        send_word(1'b1, KIND_MEAS, 16'h8000, 1'b1, 1'b0);
        send_startup(1'b1, 16'hFFFF, 1'b1, 1'b0);

        while (sent_bytes - stray_bytes < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (sent_bytes > 500 && sent_bytes < 500 + FLOOD_ITEMS) flood_on = 1'b1;
            else flood_on = 1'b0;
            if (pick < 15) begin
                send_startup(1'b1, pick_scale(), $urandom_range(0, 99) < 85,
                             $urandom_range(0, 99) < 85);
            end else if (pick < 80) begin
                send_word(1'b1, KIND_MEAS, pick_raw(), $urandom_range(0, 99) < 90,
                          1'($urandom));
            end else if (pick < 87) begin
                c = 1'($urandom);
                n = $urandom_range(1, (c == KIND_MEAS) ? 2 : 8);
                send_byte(1'b1, c, 8'($urandom), 1'($urandom));
                repeat (n - 1) send_byte(1'b0, 1'($urandom), 8'($urandom), 1'($urandom));
            end else if (pick < 94) begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(1'b0, 1'($urandom), 8'($urandom), 1'($urandom));
                stray_bytes += n;
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(1'($urandom), 1'($urandom), 8'($urandom),
                                     1'($urandom));
            end
        end
        flood_on = 1'b0;
        in_if.valid <= 1'b0;

        while (book.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.pending() != 0)
            book.report($sformatf("%0d results never arrived", book.pending()));
        if (book.fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        int            stall;
        t_frame_result got;
        got_results = 0;
        held        = 1'b0;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (flood_on && !held) begin
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                held = 1'b1;
            end else begin
                stall = ((got_results / 25) % 5 == 3) ? 0 : $urandom_range(0, 15);
                if (stall > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            got.kind       = out_if.kind;
            got.present    = out_if.present;
            got.reading_ok = out_if.reading_ok;
            got.pressure   = out_if.pressure;
            got.scale_out  = out_if.scale_out;
            book.check_result(got);
            got_results++;
        end
    end

endmodule

### pressure_frame_crc_scaler_unit.f
rtl/pfcs_pkg.sv
rtl/pfcs_in_if.sv
rtl/pfcs_out_if.sv
rtl/pressure_frame_crc_scaler_unit.sv
tb/tb_top.sv
